>>> design/php_pkg.sv
package php_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // intrinsics reset values, in millionths
    localparam longint unsigned MICRO    = 64'd1000000;
    localparam longint unsigned FX_MICRO = 64'd517306408;
    localparam longint unsigned FY_MICRO = 64'd516469215;
    localparam longint unsigned CX_MICRO = 64'd318643040;
    localparam longint unsigned CY_MICRO = 64'd255313989;

    // quotient bits resolved by the divider; anything at or above 2^QBITS saturates anyway
    localparam int QBITS = 34;

    typedef enum logic [1:0] {
        REG_FOCAL_X  = 2'd0,
        REG_FOCAL_Y  = 2'd1,
        REG_CENTER_X = 2'd2,
        REG_CENTER_Y = 2'd3
    } reg_idx_t;

    typedef enum logic {
        OP_PROJECT   = 1'b0,
        OP_UNPROJECT = 1'b1
    } op_t;

    typedef struct packed {
        logic        neg;
        logic [32:0] a;
        logic [31:0] b;
        logic [31:0] den;
    } opnd_t;

    typedef struct packed {
        logic        neg;
        logic [64:0] num;
        logic [31:0] den;
    } prod_t;

    // acc holds the low dividend bits and shifts quotient bits in from the bottom
    typedef struct packed {
        logic             neg;
        logic             big;
        logic [31:0]      den;
        logic [31:0]      rem;
        logic [QBITS-1:0] acc;
    } axis_t;

    function automatic axis_t div_init(prod_t p);
        axis_t r;
        logic [31:0] hi;
        hi    = {1'b0, p.num[64:QBITS]};
        r.neg = p.neg;
        r.den = p.den;
        r.big = (hi >= p.den);
        r.rem = hi;
        r.acc = p.num[QBITS-1:0];
        return r;
    endfunction

    function automatic axis_t div_step(axis_t s);
        axis_t       r;
        logic [32:0] t;
        logic        qb;
        r  = s;
        t  = {s.rem, s.acc[QBITS-1]};
        qb = (t >= {1'b0, s.den});
        r.rem = qb ? 32'(t - {1'b0, s.den}) : t[31:0];
        r.acc = {s.acc[QBITS-2:0], qb};
        return r;
    endfunction

    function automatic logic [31:0] sat32(logic signed [35:0] v);
        logic [31:0] r;
        if (v > 36'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -36'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // signed quotient plus offset, saturated
    function automatic logic [31:0] axis_out(axis_t s, logic [31:0] c);
        logic [QBITS:0]     q;
        logic signed [35:0] sv;
        q  = s.big ? {1'b1, {QBITS{1'b0}}} : {1'b0, s.acc};
        sv = s.neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        return sat32(sv + $signed({4'b0, c}));
    endfunction

endpackage

>>> design/pinhole_project_unproject_top.sv
// Throughput: one word per cycle while out_stall is low; each stage holds one word and the
// 34-step restoring divider (one quotient bit per stage, two lanes) sets the depth.
// Reset: rst_n clears all valid bits and loads the default intrinsics;
// payload registers are not reset.
module pinhole_project_unproject_top
    import php_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [31:0] coord_x,
    input  logic [31:0] coord_y,
    input  logic [31:0] coord_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] out_x,
    output logic [31:0] out_y,
    output logic [31:0] out_z,
    output logic        zero_depth
);

    // reset intrinsics: round(micro * 2^FRAC_BITS / 1e6), saturated to 32 bits
    localparam longint unsigned FX_Q = (FX_MICRO * (64'd1 << FRAC_BITS) + MICRO / 2) / MICRO;
    localparam longint unsigned FY_Q = (FY_MICRO * (64'd1 << FRAC_BITS) + MICRO / 2) / MICRO;
    localparam longint unsigned CX_Q = (CX_MICRO * (64'd1 << FRAC_BITS) + MICRO / 2) / MICRO;
    localparam longint unsigned CY_Q = (CY_MICRO * (64'd1 << FRAC_BITS) + MICRO / 2) / MICRO;
    localparam logic [31:0] FX_RST = (FX_Q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(FX_Q);
    localparam logic [31:0] FY_RST = (FY_Q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(FY_Q);
    localparam logic [31:0] CX_RST = (CX_Q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(CX_Q);
    localparam logic [31:0] CY_RST = (CY_Q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(CY_Q);
    localparam logic [31:0] ONE    = 32'(64'd1 << FRAC_BITS);

    // stage map: 0 operands, 1 product, 2..2+QBITS divider, last output
    localparam int DIV_N = QBITS + 1;
    localparam int NS    = DIV_N + 3;

    logic [31:0] focal_x_reg, focal_y_reg, center_x_reg, center_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= FX_RST;
            focal_y_reg  <= FY_RST;
            center_x_reg <= CX_RST;
            center_y_reg <= CY_RST;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_FOCAL_X:  focal_x_reg  <= cfg_wdata;
                REG_FOCAL_Y:  focal_y_reg  <= cfg_wdata;
                REG_CENTER_X: center_x_reg <= cfg_wdata;
                REG_CENTER_Y: center_y_reg <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    // --- valid chain: a stage moves when it is empty or the next one moves
    logic [NS-1:0] vld_reg;
    logic [NS:0]   go;

    always_comb
    begin
        go[NS] = !out_stall;
        for (int i = NS - 1; i >= 0; i--)
            go[i] = !vld_reg[i] || go[i+1];
    end

    assign in_stall = !go[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (go[0])
                vld_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++)
                if (go[i])
                    vld_reg[i] <= vld_reg[i-1];
        end
    end

    // --- stage 0: signs, magnitudes, divisors
    function automatic logic [31:0] mag32(logic [31:0] v);
        return v[31] ? 32'(-v) : v;
    endfunction

    function automatic opnd_t mk_opnd(logic op, logic [31:0] p, logic [31:0] z,
                                      logic [31:0] f, logic [31:0] c);
        opnd_t       r;
        logic [33:0] diff;
        diff = {{2{p[31]}}, p} - {2'b00, c};
        if (op == OP_UNPROJECT)
        begin
            r.neg = diff[33] ^ z[31];
            r.a   = diff[33] ? 33'(-diff) : diff[32:0];
            r.b   = mag32(z);
            r.den = (f == 32'd0) ? 32'd1 : f;
        end
        else
        begin
            r.neg = p[31] ^ z[31];
            r.a   = {1'b0, mag32(p)};
            r.b   = f;
            r.den = (z == 32'd0) ? 32'd1 : mag32(z);
        end
        return r;
    endfunction

    logic        s0_op_reg, s0_zero_reg;
    logic [31:0] s0_z_reg;
    opnd_t       s0_x_reg, s0_y_reg;

    always_ff @(posedge clk)
    begin
        if (go[0])
        begin
            s0_op_reg   <= opcode;
            s0_zero_reg <= (coord_z == 32'd0);
            s0_z_reg    <= coord_z;
            s0_x_reg    <= mk_opnd(opcode, coord_x, coord_z, focal_x_reg, center_x_reg);
            s0_y_reg    <= mk_opnd(opcode, coord_y, coord_z, focal_y_reg, center_y_reg);
        end
    end

    // --- stage 1: products, full 65-bit width
    logic        s1_op_reg, s1_zero_reg;
    logic [31:0] s1_z_reg;
    prod_t       s1_x_reg, s1_y_reg;

    always_ff @(posedge clk)
    begin
        if (go[1])
        begin
            s1_op_reg     <= s0_op_reg;
            s1_zero_reg   <= s0_zero_reg;
            s1_z_reg      <= s0_z_reg;
            s1_x_reg.neg  <= s0_x_reg.neg;
            s1_x_reg.num  <= {32'b0, s0_x_reg.a} * {33'b0, s0_x_reg.b};
            s1_x_reg.den  <= s0_x_reg.den;
            s1_y_reg.neg  <= s0_y_reg.neg;
            s1_y_reg.num  <= {32'b0, s0_y_reg.a} * {33'b0, s0_y_reg.b};
            s1_y_reg.den  <= s0_y_reg.den;
        end
    end

    // --- divider: entry 0 holds the overflow check, then one bit per entry
    logic        dv_op_reg   [DIV_N];
    logic        dv_zero_reg [DIV_N];
    logic [31:0] dv_z_reg    [DIV_N];
    axis_t       dv_x_reg    [DIV_N];
    axis_t       dv_y_reg    [DIV_N];

    always_ff @(posedge clk)
    begin
        if (go[2])
        begin
            dv_op_reg[0]   <= s1_op_reg;
            dv_zero_reg[0] <= s1_zero_reg;
            dv_z_reg[0]    <= s1_z_reg;
            dv_x_reg[0]    <= div_init(s1_x_reg);
            dv_y_reg[0]    <= div_init(s1_y_reg);
        end
        for (int k = 1; k < DIV_N; k++)
            if (go[k+2])
            begin
                dv_op_reg[k]   <= dv_op_reg[k-1];
                dv_zero_reg[k] <= dv_zero_reg[k-1];
                dv_z_reg[k]    <= dv_z_reg[k-1];
                dv_x_reg[k]    <= div_step(dv_x_reg[k-1]);
                dv_y_reg[k]    <= div_step(dv_y_reg[k-1]);
            end
    end

    // --- output stage: sign, offset, saturation, zero-depth case
    logic        op_l, zero_l;
    logic [31:0] x_next, y_next, z_next;
    logic        zd_next;

    always_comb
    begin
        op_l   = dv_op_reg[DIV_N-1];
        zero_l = dv_zero_reg[DIV_N-1];
        if (op_l == OP_UNPROJECT)
        begin
            x_next  = axis_out(dv_x_reg[DIV_N-1], 32'd0);
            y_next  = axis_out(dv_y_reg[DIV_N-1], 32'd0);
            z_next  = dv_z_reg[DIV_N-1];
            zd_next = 1'b0;
        end
        else if (zero_l)
        begin
            x_next  = 32'd0;
            y_next  = 32'd0;
            z_next  = 32'd0;
            zd_next = 1'b1;
        end
        else
        begin
            x_next  = axis_out(dv_x_reg[DIV_N-1], center_x_reg);
            y_next  = axis_out(dv_y_reg[DIV_N-1], center_y_reg);
            z_next  = ONE;
            zd_next = 1'b0;
        end
    end

    logic [31:0] out_x_reg, out_y_reg, out_z_reg;
    logic        zd_reg;

    always_ff @(posedge clk)
    begin
        if (go[NS-1])
        begin
            out_x_reg <= x_next;
            out_y_reg <= y_next;
            out_z_reg <= z_next;
            zd_reg    <= zd_next;
        end
    end

    assign out_valid  = vld_reg[NS-1];
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign out_z      = out_z_reg;
    assign zero_depth = zd_reg;

endmodule

>>> design/php_checker.sv
module php_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] out_x,
    input logic [31:0] out_y,
    input logic [31:0] out_z,
    input logic        zero_depth
);

    a_rst_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_depth |-> out_x == 32'd0 && out_y == 32'd0 && out_z == 32'd0)
        else $error("zero depth word with nonzero payload");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
            && $stable(out_z) && $stable(zero_depth))
        else $error("stalled output word changed");

endmodule

bind pinhole_project_unproject_top php_checker u_php_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .zero_depth (zero_depth)
);
